FILE: hdl/pc_trace_ring_with_range_trigger_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trace ring block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PC_TRACE_RING_WITH_RANGE_TRIGGER_CORE_MACROS_SVH
`define PC_TRACE_RING_WITH_RANGE_TRIGGER_CORE_MACROS_SVH

// Overlapping implication: consequent checked in the same cycle.
`define PCTR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: consequent checked in the next cycle.
`define PCTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pctr_pkg.sv
// ----------------------------------------------------------------------------
// pctr_pkg
// Shared types and constants of the trace ring with range trigger.
// ----------------------------------------------------------------------------
package pctr_pkg;

    localparam int ADDR_W         = 64;
    localparam int AGE_W          = 5;
    localparam int READOUT_MAX    = 32;
    localparam int RING_DEPTH_DEF = 32;
    localparam int SLOT_MAX_W     = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int CMDQ_DEPTH     = 2;
    localparam int OUTQ_DEPTH     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WATCH_LOW  = 2'd0,
        REG_WATCH_HIGH = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RD_IDLE  = 2'd0,
        RD_CHECK = 2'd1,
        RD_LAST  = 2'd2
    } rd_state_t;

    // Ring write from the capture side
    typedef struct packed {
        logic                  en;
        logic [SLOT_MAX_W-1:0] slot;
        logic [ADDR_W-1:0]     data;
    } ring_wr_t;

    // Readout request: triggering address and the slot it went to
    typedef struct packed {
        logic [ADDR_W-1:0]     addr;
        logic [SLOT_MAX_W-1:0] newest;
    } cmd_t;

    typedef struct packed {
        logic [AGE_W-1:0]  age;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } result_t;

endpackage

FILE: hdl/pc_trace_ring_with_range_trigger_core.sv
// ----------------------------------------------------------------------------
// pc_trace_ring_with_range_trigger_core
// Trace ring of recent block addresses with an address-range readout trigger.
// ----------------------------------------------------------------------------
// Each pushed block_address is written into a ring of the RING_DEPTH most
// recent addresses. When the address lies in [watch_low, watch_high), the
// block produces a readout of the ring, newest entry first: age 0 is the
// triggering address, and the readout ends after min(RING_DEPTH, 32) results
// or just before a zero entry (slots not yet written since reset count as
// zero). After reset watch_low is 1 and watch_high is 0, so nothing triggers.
// A non-triggering address is taken every cycle while no readout is pending.
// A triggering address raises full from the next cycle until the readout
// engine has issued its last result; the engine reads one ring slot per
// cycle, while the output queue has room, through the ring memory's single
// registered read port. Results wait in a two-beat output queue, so the
// engine keeps running while a beat is unpopped.
// The ring needs no clearing pass after reset: a fill count marks which slots
// have been written. Write configuration only while no readout is pending.
// ----------------------------------------------------------------------------
module pc_trace_ring_with_range_trigger_core #(
    parameter int RING_DEPTH = pctr_pkg::RING_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_write,
    input  logic [pctr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pctr_pkg::ADDR_W-1:0]      cfg_data,
    // address input queue side
    input  logic                             push,
    output logic                             full,
    input  logic [pctr_pkg::ADDR_W-1:0]      block_address,
    // result queue side
    output logic                             empty,
    input  logic                             pop,
    output logic [pctr_pkg::AGE_W-1:0]       age,
    output logic [pctr_pkg::ADDR_W-1:0]      recorded_address,
    output logic                             last
);
    import pctr_pkg::*;

    localparam int FW = $clog2(RING_DEPTH + 1);

    ring_wr_t      ring_wr;
    logic [FW-1:0] fill;
    logic          back_busy;
    logic          cmd_push, cmd_pop, cmd_full, cmd_empty;
    cmd_t          cmd_in, cmd_out;
    logic          oq_push, oq_full;
    result_t       oq_in, oq_out;

    // Capture: record every beat, flag range hits
    pctr_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .block_address (block_address),
        .back_busy     (back_busy),
        .cmd_full      (cmd_full),
        .cmd_empty     (cmd_empty),
        .cmd_push      (cmd_push),
        .cmd_data      (cmd_in),
        .ring_wr       (ring_wr),
        .fill          (fill)
    );

    // Readout requests between capture and readout engine
    pctr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    // Readout engine with the ring memory
    pctr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ring_wr   (ring_wr),
        .fill      (fill),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .busy      (back_busy),
        .oq_full   (oq_full),
        .oq_push   (oq_push),
        .oq_data   (oq_in)
    );

    // Result queue: hold beats until popped
    pctr_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .din   (oq_in),
        .full  (oq_full),
        .pop   (pop),
        .dout  (oq_out),
        .empty (empty)
    );

    assign age              = oq_out.age;
    assign recorded_address = oq_out.addr;
    assign last             = oq_out.last;

endmodule

FILE: hdl/pctr_fifo.sv
// ----------------------------------------------------------------------------
// pctr_fifo
// Small register FIFO used between front and back and on the result side.
// ----------------------------------------------------------------------------
module pctr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hdl/pctr_front.sv
// ----------------------------------------------------------------------------
// pctr_front
// Capture side: holds the watch range, writes each address into the ring and
// issues a readout request when the address falls in the range.
// ----------------------------------------------------------------------------
module pctr_front #(
    parameter int RING_DEPTH = pctr_pkg::RING_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [pctr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pctr_pkg::ADDR_W-1:0]          cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic [pctr_pkg::ADDR_W-1:0]          block_address,
    input  logic                                 back_busy,
    input  logic                                 cmd_full,
    input  logic                                 cmd_empty,
    output logic                                 cmd_push,
    output pctr_pkg::cmd_t                       cmd_data,
    output pctr_pkg::ring_wr_t                   ring_wr,
    output logic [$clog2(RING_DEPTH + 1)-1:0]    fill
);
    import pctr_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);

    logic [ADDR_W-1:0] watch_low_reg;
    logic [ADDR_W-1:0] watch_high_reg;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic              accept;
    logic              hit;

    // Hold input while any readout is queued or running
    assign full   = cmd_full || !cmd_empty || back_busy;
    assign accept = push && !full;
    assign hit    = (block_address >= watch_low_reg) && (block_address < watch_high_reg);
    assign fill   = fill_reg;

    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            wp_next   = (wp_reg == AW'(RING_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            fill_next = (fill_reg == FW'(RING_DEPTH)) ? fill_reg : fill_reg + FW'(1);
        end
        ring_wr.en      = accept;
        ring_wr.slot    = SLOT_MAX_W'(wp_reg);
        ring_wr.data    = block_address;
        cmd_push        = accept && hit;
        cmd_data.addr   = block_address;
        cmd_data.newest = SLOT_MAX_W'(wp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_low_reg  <= ADDR_W'(1);
            watch_high_reg <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_WATCH_LOW:  watch_low_reg  <= cfg_data;
                    REG_WATCH_HIGH: watch_high_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

endmodule

FILE: hdl/pctr_back.sv
// ----------------------------------------------------------------------------
// pctr_back
// Readout side: owns the ring memory and walks it newest first for each
// request, one entry per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module pctr_back #(
    parameter int RING_DEPTH = pctr_pkg::RING_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pctr_pkg::ring_wr_t                   ring_wr,
    input  logic [$clog2(RING_DEPTH + 1)-1:0]    fill,
    input  logic                                 cmd_empty,
    input  pctr_pkg::cmd_t                       cmd_data,
    output logic                                 cmd_pop,
    output logic                                 busy,
    input  logic                                 oq_full,
    output logic                                 oq_push,
    output pctr_pkg::result_t                    oq_data
);
    import pctr_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int FW    = $clog2(RING_DEPTH + 1);
    localparam int LIMIT = (RING_DEPTH < READOUT_MAX) ? RING_DEPTH : READOUT_MAX;

    logic [ADDR_W-1:0] ring_mem [RING_DEPTH];

    rd_state_t         state_reg, state_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [AGE_W-1:0]  pend_age_reg, pend_age_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [AW-1:0]     rd_addr;
    logic [ADDR_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [AGE_W-1:0]  age_k;
    logic              more;

    function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] s);
        prev_slot = (s == '0) ? AW'(RING_DEPTH - 1) : s - AW'(1);
    endfunction

    assign busy  = (state_reg != RD_IDLE);
    assign age_k = pend_age_reg + AGE_W'(1);
    // Slots never written since reset end the readout like a zero entry
    assign more  = rd_valid_reg && (rd_data_reg != '0);

    always_comb
    begin
        state_next     = state_reg;
        pend_addr_next = pend_addr_reg;
        pend_age_next  = pend_age_reg;
        slot_next      = slot_reg;
        rd_addr        = slot_reg;
        cmd_pop        = 1'b0;
        oq_push        = 1'b0;
        oq_data.age    = pend_age_reg;
        oq_data.addr   = pend_addr_reg;
        oq_data.last   = 1'b1;
        unique case (state_reg)
            RD_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop        = 1'b1;
                    pend_addr_next = cmd_data.addr;
                    pend_age_next  = '0;
                    slot_next      = prev_slot(AW'(cmd_data.newest));
                    rd_addr        = slot_next;
                    state_next     = RD_CHECK;
                end
            end
            RD_CHECK:
            begin
                if (!oq_full)
                begin
                    oq_push      = 1'b1;
                    oq_data.last = !more;
                    if (more)
                    begin
                        pend_addr_next = rd_data_reg;
                        pend_age_next  = age_k;
                        if (({1'b0, age_k} + (AGE_W + 1)'(1)) < (AGE_W + 1)'(LIMIT))
                        begin
                            slot_next = prev_slot(slot_reg);
                            rd_addr   = slot_next;
                        end
                        else
                        begin
                            state_next = RD_LAST;
                        end
                    end
                    else
                    begin
                        state_next = RD_IDLE;
                    end
                end
            end
            RD_LAST:
            begin
                if (!oq_full)
                begin
                    oq_push    = 1'b1;
                    state_next = RD_IDLE;
                end
            end
            default:
            begin
                state_next = RD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= RD_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (FW'(rd_addr) < fill);
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_age_reg  <= pend_age_next;
        slot_reg      <= slot_next;
    end

    // Ring memory: one write port from capture, one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_wr.en)
        begin
            ring_mem[AW'(ring_wr.slot)] <= ring_wr.data;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

endmodule

FILE: hdl/pctr_checker.sv
// ----------------------------------------------------------------------------
// pctr_checker
// Port-level checks of the trace ring, bound to the top level.
// ----------------------------------------------------------------------------
`include "pc_trace_ring_with_range_trigger_core_macros.svh"

module pctr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             push,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic [pctr_pkg::AGE_W-1:0]       age,
    input logic [pctr_pkg::ADDR_W-1:0]      recorded_address,
    input logic                             last
);
    import pctr_pkg::*;

    logic [AGE_W-1:0] exp_age_reg;

    // Track the age the next beat must carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_age_reg <= '0;
        end
        else if (pop && !empty)
        begin
            exp_age_reg <= last ? '0 : age + AGE_W'(1);
        end
    end

    `PCTR_ASSERT_SAME(a_age_in_order, !empty, age == exp_age_reg, "readout age out of order")
    `PCTR_ASSERT_NEXT(a_head_holds, !empty && !pop,
        !empty && $stable(recorded_address) && $stable(age) && $stable(last),
        "result head changed while not popped")
    `PCTR_ASSERT_SAME(a_full_after_push, $rose(full), $past(push && !full),
        "full rose without an accepted address")
    `PCTR_ASSERT_SAME(a_empty_after_pop, $rose(empty), $past(pop),
        "result went away without a pop")

endmodule

bind pc_trace_ring_with_range_trigger_core pctr_checker u_pctr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .age              (age),
    .recorded_address (recorded_address),
    .last             (last)
);
